/* src/tfd_pkg.sv */
// ----------------------------------------------------------------------------
// tfd_pkg
// Shared types and constants of the TLV frame dispatcher: parser phases,
// result kinds, frame tags and the command word carried from front to back.
// ----------------------------------------------------------------------------
package tfd_pkg;

  typedef enum logic [1:0] {
    PH_LEN = 2'd0,
    PH_TAG = 2'd1,
    PH_PAY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_IR     = 2'd1,
    KIND_REG    = 2'd2
  } kind_t;

  localparam logic [7:0] TAG_STATUS   = 8'h00;
  localparam logic [7:0] TAG_IR       = 8'h03;
  localparam logic [7:0] TAG_REG      = 8'h06;
  localparam logic [7:0] TAG_IR_PARAM = 8'h08;

  localparam logic [7:0] REG_FRAME_LEN = 8'd6;
  localparam int unsigned REG_WORDS    = 16;

  localparam int unsigned STATUS_LEN   = 8;
  localparam int unsigned STATUS_CNT_W = $clog2(STATUS_LEN);
  localparam logic [7:0] STATUS_REPLY [STATUS_LEN] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00
  };

  // One command from the parser, also the layout of one output word.
  typedef struct packed {
    kind_t        kind;
    logic [7:0]   data;
    logic [15:0]  param;
    logic [3:0]   index;
    logic [31:0]  value;
    logic         last;
  } cmd_t;

endpackage

/* src/tfd_if.sv */
// ----------------------------------------------------------------------------
// tfd_in_if / tfd_out_if
// Valid/ready channels of the TLV frame dispatcher: the byte stream in and
// the result words out.
// ----------------------------------------------------------------------------
interface tfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface tfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_byte;
  logic [15:0] ir_param;
  logic [3:0]  reg_index;
  logic [31:0] reg_value;
  logic        last;

  modport source (output valid, output kind, output out_byte, output ir_param,
                  output reg_index, output reg_value, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input ir_param,
                  input reg_index, input reg_value, input last, output ready);
endinterface

/* src/tlv_frame_dispatcher_core.sv */
// ----------------------------------------------------------------------------
// tlv_frame_dispatcher_core
// Length-prefixed TLV deframer: status replies, register writes and IR bytes.
// ----------------------------------------------------------------------------
// The block takes one stream byte per word on in_ch and sustains one byte per
// cycle. Each frame is a length byte, a tag byte and that many payload bytes.
// IR payload bytes (tag 0x03, and tag 0x08 after its two parameter bytes) are
// forwarded as they arrive; a register frame (tag 0x06, length 6, offset below
// 16) gives one register-write word at its end; a status frame (tag 0x00) gives
// an eight-word reply at its end. A result word reaches out_ch through the
// queue register and then the output register. The result stage emits one
// word per cycle while out_ch.ready is high, so a status reply occupies it
// for eight output words; the command queue of QUEUE_DEPTH entries absorbs
// the bytes that follow, and in_ch.ready drops only while that queue is full.
// ----------------------------------------------------------------------------
module tlv_frame_dispatcher_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  tfd_in_if.sink     in_ch,
  tfd_out_if.source  out_ch
);

  localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1);

  // Front to queue
  logic           q_push;
  tfd_pkg::cmd_t  q_cmd;
  logic           q_ready;

  // Queue to back
  logic           q_head_valid;
  tfd_pkg::cmd_t  q_head;
  logic           q_pop;
  logic [LW-1:0]  q_level;

  // Parse the byte stream; push one command per byte at most.
  tfd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  // Hold commands while the result stage is busy or stalled.
  tfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .ready      (q_ready),
    .head_valid (q_head_valid),
    .head_cmd   (q_head),
    .pop        (q_pop),
    .level      (q_level)
  );

  // Expand commands into output words and drive the result channel.
  tfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_cmd   (q_head),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

  // Never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_level < LW'(QUEUE_DEPTH)))
    else $error("command pushed into full queue");

  // Never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_level != '0))
    else $error("command popped from empty queue");

  // Drop the output word on reset.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

endmodule

/* src/tfd_front.sv */
// ----------------------------------------------------------------------------
// tfd_front
// Frame parser: takes one stream byte per word, tracks the frame phase and
// pushes at most one command per byte into the queue.
// ----------------------------------------------------------------------------
module tfd_front (
  input  logic           clk,
  input  logic           rst_n,
  tfd_in_if.sink         in_ch,
  input  logic           q_ready,
  output logic           q_push,
  output tfd_pkg::cmd_t  q_cmd
);

  tfd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [7:0]  off_r, off_nxt;
  logic [15:0] param_r, param_nxt;
  logic [31:0] value_r, value_nxt;

  logic       acc;
  logic [7:0] b;
  logic [7:0] idx;
  logic [7:0] rem_dec;
  logic       lastb;
  logic       emit_ir;
  logic       reg_frame;

  assign in_ch.ready = q_ready;
  assign acc         = in_ch.valid && q_ready;
  assign b           = in_ch.in_byte;
  assign idx         = len_r - rem_r;
  assign rem_dec     = rem_r - 8'd1;
  assign lastb       = (rem_dec == 8'd0);
  assign reg_frame   = (tag_r == tfd_pkg::TAG_REG) && (len_r == tfd_pkg::REG_FRAME_LEN);

  always_comb begin
    phase_nxt = phase_r;
    rem_nxt   = rem_r;
    len_nxt   = len_r;
    tag_nxt   = tag_r;
    off_nxt   = off_r;
    param_nxt = param_r;
    value_nxt = value_r;
    emit_ir   = 1'b0;
    q_push    = 1'b0;
    q_cmd     = '0;
    if (acc) begin
      unique case (phase_r)
        tfd_pkg::PH_TAG: begin
          tag_nxt = b;
          if (rem_r == 8'd0) begin
            phase_nxt = tfd_pkg::PH_LEN;
            if (b == tfd_pkg::TAG_STATUS) begin
              q_push     = 1'b1;
              q_cmd.kind = tfd_pkg::KIND_STATUS;
            end
          end else begin
            phase_nxt = tfd_pkg::PH_PAY;
          end
        end
        tfd_pkg::PH_PAY: begin
          rem_nxt = rem_dec;
          if (tag_r == tfd_pkg::TAG_IR) begin
            emit_ir = 1'b1;
          end else if (tag_r == tfd_pkg::TAG_IR_PARAM) begin
            if (idx == 8'd0) begin
              param_nxt[7:0] = b;
            end else if (idx == 8'd1) begin
              param_nxt[15:8] = b;
            end else begin
              emit_ir = 1'b1;
            end
          end else if (reg_frame) begin
            unique case (idx)
              8'd0:    off_nxt = b;
              8'd2:    value_nxt[7:0]   = b;
              8'd3:    value_nxt[15:8]  = b;
              8'd4:    value_nxt[23:16] = b;
              8'd5:    value_nxt[31:24] = b;
              default: ;
            endcase
          end
          if (emit_ir) begin
            q_push      = 1'b1;
            q_cmd.kind  = tfd_pkg::KIND_IR;
            q_cmd.data  = b;
            q_cmd.param = (tag_r == tfd_pkg::TAG_IR_PARAM) ? param_r : 16'd0;
            q_cmd.last  = lastb;
          end
          if (lastb) begin
            phase_nxt = tfd_pkg::PH_LEN;
            if (!emit_ir) begin
              if (tag_r == tfd_pkg::TAG_STATUS) begin
                q_push     = 1'b1;
                q_cmd.kind = tfd_pkg::KIND_STATUS;
              end else if (reg_frame &&
                           ({1'b0, off_nxt} < 9'(tfd_pkg::REG_WORDS))) begin
                q_push      = 1'b1;
                q_cmd.kind  = tfd_pkg::KIND_REG;
                q_cmd.index = off_nxt[3:0];
                q_cmd.value = value_nxt;
              end
            end
          end
        end
        default: begin
          len_nxt   = b;
          rem_nxt   = b;
          phase_nxt = tfd_pkg::PH_TAG;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tfd_pkg::PH_LEN;
      rem_r   <= 8'd0;
      len_r   <= 8'd0;
      tag_r   <= 8'd0;
      off_r   <= 8'd0;
      param_r <= 16'd0;
      value_r <= 32'd0;
    end else begin
      phase_r <= phase_nxt;
      rem_r   <= rem_nxt;
      len_r   <= len_nxt;
      tag_r   <= tag_nxt;
      off_r   <= off_nxt;
      param_r <= param_nxt;
      value_r <= value_nxt;
    end
  end

endmodule

/* src/tfd_queue.sv */
// ----------------------------------------------------------------------------
// tfd_queue
// Small command FIFO between parser and result stage.
// ----------------------------------------------------------------------------
module tfd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  tfd_pkg::cmd_t                 push_cmd,
  output logic                          ready,
  output logic                          head_valid,
  output tfd_pkg::cmd_t                 head_cmd,
  input  logic                          pop,
  output logic [$clog2(DEPTH+1)-1:0]    level
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);

  tfd_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;

  assign ready      = (cnt_r != LW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign level      = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    priority if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* src/tfd_back.sv */
// ----------------------------------------------------------------------------
// tfd_back
// Result stage: turns queued commands into output words, expanding a status
// command into the eight-byte reply, and holds them in an output register.
// ----------------------------------------------------------------------------
module tfd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  tfd_pkg::cmd_t  head_cmd,
  output logic           pop,
  tfd_out_if.source      out_ch
);

  logic                              ov_r, ov_nxt;
  tfd_pkg::cmd_t                     word_r, word_nxt;
  logic [tfd_pkg::STATUS_CNT_W-1:0]  scnt_r, scnt_nxt;
  logic                              load;
  logic                              slast;

  assign load  = !ov_r || out_ch.ready;
  assign slast = (scnt_r == tfd_pkg::STATUS_CNT_W'(tfd_pkg::STATUS_LEN - 1));

  always_comb begin
    ov_nxt   = ov_r && !out_ch.ready;
    word_nxt = word_r;
    scnt_nxt = scnt_r;
    pop      = 1'b0;
    if (load && head_valid) begin
      ov_nxt = 1'b1;
      if (head_cmd.kind == tfd_pkg::KIND_STATUS) begin
        word_nxt      = '0;
        word_nxt.kind = tfd_pkg::KIND_STATUS;
        word_nxt.data = tfd_pkg::STATUS_REPLY[scnt_r];
        word_nxt.last = slast;
        if (slast) begin
          scnt_nxt = '0;
          pop      = 1'b1;
        end else begin
          scnt_nxt = scnt_r + 1'b1;
        end
      end else begin
        word_nxt = head_cmd;
        pop      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      scnt_r <= '0;
    end else begin
      ov_r   <= ov_nxt;
      scnt_r <= scnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.kind      = 2'(word_r.kind);
  assign out_ch.out_byte  = word_r.data;
  assign out_ch.ir_param  = word_r.param;
  assign out_ch.reg_index = word_r.index;
  assign out_ch.reg_value = word_r.value;
  assign out_ch.last      = word_r.last;

endmodule
